// ===== design/keyword_hash_table_unit_macros.svh =====
// Assertion macros shared by the keyword hash table RTL.
`ifndef KEYWORD_HASH_TABLE_UNIT_MACROS_SVH
`define KEYWORD_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KHT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/kht_pkg.sv =====
// Package of the keyword hash table: default sizes, operation codes and item types.
package kht_pkg;

   localparam int KHT_TABLE_ENTRIES = 64;
   localparam int KHT_MAX_KEY_LEN   = 16;
   localparam int KHT_HASH_W        = 16;
   localparam int KHT_SLOT_OUT_W    = 6;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] key_char;
      logic       last_char;
      logic [7:0] token_value;
   } req_item_type;

   typedef struct packed {
      logic                      found;
      logic [7:0]                result_value;
      logic [KHT_SLOT_OUT_W-1:0] slot_index;
      logic                      key_overflow;
   } rsp_item_type;

endpackage

// ===== design/kht_stream_if.sv =====
// Valid/ready stream interface used for the request and response channels.
interface kht_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/keyword_hash_table_unit.sv =====
// A key byte without the last flag keeps the unit in IDLE; the next byte may follow in the
// next cycle. After the last byte, an overflowed key goes straight to DONE; otherwise MOD runs
// first when TABLE_ENTRIES is not a power of two, then an insert passes WRITE and a search
// SEARCH and DRAIN, one key byte per cycle. No request is taken until DONE loads the response.
// Reset is synchronous and active high: it clears the sequencer, the hash accumulator and the
// slot valid marks at once; the key, length and value memories are not cleared.
`include "keyword_hash_table_unit_macros.svh"

module keyword_hash_table_unit import kht_pkg::*; #(
   parameter int TABLE_ENTRIES = KHT_TABLE_ENTRIES,
   parameter int MAX_KEY_LEN   = KHT_MAX_KEY_LEN
) (
   input  logic        clock,
   input  logic        reset,
   kht_stream_if.sink   req,
   kht_stream_if.source rsp
);

   // Slot index, byte position and key length widths all follow the parameters.
   // The key memory gives every slot a power-of-two stride so that the address is
   // simply the slot number joined to the byte position.
   localparam int  IDX_W        = $clog2(TABLE_ENTRIES);
   localparam int  POS_W        = $clog2(MAX_KEY_LEN);
   localparam int  LEN_W        = $clog2(MAX_KEY_LEN + 1);
   localparam int  PROD_W       = 8 + LEN_W;
   localparam int  KEY_DEPTH    = TABLE_ENTRIES << POS_W;
   localparam bit  TABLE_POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

   // Reciprocal of the table size, rounded up. With the shift set to the hash width plus
   // the slot index width, the quotient is exact for every 16-bit hash.
   localparam int  RECIP_SH     = KHT_HASH_W + IDX_W;
   localparam int  RECIP_MUL    = ((1 << RECIP_SH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
   localparam int  RECIP_W      = KHT_HASH_W + 1;
   localparam int  RECIP_PROD_W = KHT_HASH_W + RECIP_W;
   localparam int  BACK_W       = KHT_HASH_W + IDX_W + 1;

   // The sequencer. IDLE takes key bytes; MOD takes the remainder in two steps when the
   // table size is not a power of two; WRITE copies the buffered key into its slot; SEARCH
   // reads the stored key one byte per cycle and DRAIN compares the last byte read.
   // DONE holds the result until the response register is free.
   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_WRITE,
      S_SEARCH,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type                 state_ff;
   logic [KHT_HASH_W-1:0]     hash_ff;
   logic [LEN_W-1:0]          pos_ff;
   logic                      ovf_ff;
   logic                      op_ff;
   logic [7:0]                val_ff;
   logic [IDX_W-1:0]          slot_ff;
   logic                      mod_step_ff;
   logic [KHT_HASH_W-1:0]     quot_ff;
   logic [POS_W-1:0]          idx_ff;
   logic [POS_W-1:0]          cmp_idx_ff;
   logic                      cmp_pend_ff;
   logic                      mismatch_ff;
   logic                      res_found_ff;
   logic [7:0]                res_value_ff;
   logic [TABLE_ENTRIES-1:0]  slot_valid_ff;
   logic                      rsp_valid_ff;
   rsp_item_type              rsp_item_ff;

   // Key buffer for the key in flight, and the table memories.
   logic [7:0]                key_buf_ff [MAX_KEY_LEN];
   logic [7:0]                key_mem    [KEY_DEPTH];
   logic [LEN_W-1:0]          len_mem    [TABLE_ENTRIES];
   logic [7:0]                val_mem    [TABLE_ENTRIES];
   logic [7:0]                key_rd_ff;
   logic [LEN_W-1:0]          len_rd_ff;
   logic [7:0]                val_rd_ff;

   logic                      req_fire;
   logic                      at_max;
   logic [LEN_W-1:0]          pos_inc;
   logic [PROD_W-1:0]         prod;
   logic [KHT_HASH_W-1:0]     hash_in;
   logic [LEN_W-1:0]          pos_in;
   logic                      ovf_in;
   logic [RECIP_PROD_W-1:0]   recip_prod;
   logic [KHT_HASH_W-1:0]     quot_in;
   logic [BACK_W-1:0]         back_prod;
   logic [IDX_W-1:0]          rem_in;
   logic [IDX_W+POS_W-1:0]    key_addr;
   logic [POS_W-1:0]          buf_rd_idx;
   logic [7:0]                buf_rd;
   logic                      last_idx;
   logic                      mismatch_in;
   logic                      found_in;
   state_type                 walk_state;

   assign req.ready   = (state_ff == S_IDLE);
   assign req_fire    = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_item_ff;

   // Hash accumulation: each byte adds byte * (position + 1), wrapping at 16 bits.
   // Once the buffer is full the position saturates and further bytes only mark overflow.
   always_comb begin
      at_max  = (pos_ff >= LEN_W'(MAX_KEY_LEN));
      pos_inc = pos_ff + LEN_W'(1);
      prod    = PROD_W'(req.payload.key_char) * PROD_W'(pos_inc);
      hash_in = at_max ? hash_ff : hash_ff + KHT_HASH_W'(prod);
      pos_in  = at_max ? pos_ff : pos_inc;
      ovf_in  = ovf_ff | at_max;
   end

   // Remainder by the table size: the first MOD step multiplies the hash by the reciprocal
   // to get the quotient, the second takes quotient times table size off the hash.
   always_comb begin
      recip_prod = RECIP_PROD_W'(hash_ff) * RECIP_PROD_W'(RECIP_MUL);
      quot_in    = KHT_HASH_W'(recip_prod >> RECIP_SH);
      back_prod  = BACK_W'(quot_ff) * BACK_W'(TABLE_ENTRIES);
      rem_in     = IDX_W'(hash_ff - KHT_HASH_W'(back_prod));
   end

   // The key buffer has a single read port: the write walk reads at the walk index, the
   // search compares against the byte whose stored copy came back this cycle.
   always_comb begin
      key_addr    = {slot_ff, idx_ff};
      buf_rd_idx  = (state_ff == S_WRITE) ? idx_ff : cmp_idx_ff;
      buf_rd      = key_buf_ff[buf_rd_idx];
      last_idx    = (LEN_W'(idx_ff) == pos_ff - LEN_W'(1));
      mismatch_in = mismatch_ff | (cmp_pend_ff && (key_rd_ff != buf_rd));
      found_in    = slot_valid_ff[slot_ff] && (len_rd_ff == pos_ff) && !mismatch_in;
      walk_state  = (op_ff == OP_SEARCH) ? S_SEARCH : S_WRITE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hash_ff       <= '0;
         pos_ff        <= '0;
         ovf_ff        <= 1'b0;
         cmp_pend_ff   <= 1'b0;
         mismatch_ff   <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // A taken response empties the register, unless DONE refills it in the same cycle.
         if (rsp.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  hash_ff     <= hash_in;
                  pos_ff      <= pos_in;
                  ovf_ff      <= ovf_in;
                  op_ff       <= req.payload.operation;
                  val_ff      <= req.payload.token_value;
                  idx_ff      <= '0;
                  cmp_pend_ff <= 1'b0;
                  mismatch_ff <= 1'b0;
                  if (req.payload.last_char) begin
                     if (ovf_in) begin
                        res_found_ff <= 1'b0;
                        res_value_ff <= 8'd0;
                        state_ff     <= S_DONE;
                     end else if (TABLE_POW2) begin
                        slot_ff  <= hash_in[IDX_W-1:0];
                        state_ff <= (req.payload.operation == OP_SEARCH) ? S_SEARCH : S_WRITE;
                     end else begin
                        mod_step_ff <= 1'b0;
                        state_ff    <= S_MOD;
                     end
                  end
               end
            end
            S_MOD: begin
               if (!mod_step_ff) begin
                  quot_ff     <= quot_in;
                  mod_step_ff <= 1'b1;
               end else begin
                  slot_ff  <= rem_in;
                  state_ff <= walk_state;
               end
            end
            S_WRITE: begin
               slot_valid_ff[slot_ff] <= 1'b1;
               if (last_idx) begin
                  res_found_ff <= 1'b0;
                  res_value_ff <= 8'd0;
                  state_ff     <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + POS_W'(1);
               end
            end
            S_SEARCH: begin
               cmp_idx_ff  <= idx_ff;
               cmp_pend_ff <= 1'b1;
               mismatch_ff <= mismatch_in;
               if (last_idx) begin
                  state_ff <= S_DRAIN;
               end else begin
                  idx_ff <= idx_ff + POS_W'(1);
               end
            end
            S_DRAIN: begin
               res_found_ff <= found_in;
               res_value_ff <= found_in ? val_rd_ff : 8'd0;
               state_ff     <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_item_ff.found         <= res_found_ff;
                  rsp_item_ff.result_value  <= res_value_ff;
                  rsp_item_ff.slot_index    <= ovf_ff ? '0 : KHT_SLOT_OUT_W'(slot_ff);
                  rsp_item_ff.key_overflow  <= ovf_ff;
                  hash_ff                   <= '0;
                  pos_ff                    <= '0;
                  ovf_ff                    <= 1'b0;
                  state_ff                  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Bytes past the buffer length are dropped.
   always_ff @(posedge clock) begin
      if (req_fire && !at_max) begin
         key_buf_ff[pos_ff[POS_W-1:0]] <= req.payload.key_char;
      end
   end

   // Stored key bytes: at most one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         key_mem[key_addr] <= buf_rd;
      end
      key_rd_ff <= key_mem[key_addr];
   end

   // Stored length and token value of each slot, read at the current slot every cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         len_mem[slot_ff] <= pos_ff;
         val_mem[slot_ff] <= val_ff;
      end
      len_rd_ff <= len_mem[slot_ff];
      val_rd_ff <= val_mem[slot_ff];
   end

   `KHT_ASSERT_NEXT(a_last_byte_blocks, req.valid && req.ready && req.payload.last_char, !req.ready, "request taken in the cycle after a last byte")
   `KHT_ASSERT_SAME(a_overflow_zeroes, rsp.valid && rsp.payload.key_overflow, !rsp.payload.found && rsp.payload.result_value == 8'd0 && rsp.payload.slot_index == '0, "overflow response carries a slot or a value")
   `KHT_ASSERT_SAME(a_pos_bounded, 1'b1, pos_ff <= LEN_W'(MAX_KEY_LEN), "byte position ran past the buffer length")
   `KHT_ASSERT_SAME(a_walk_in_key, state_ff == S_WRITE || state_ff == S_SEARCH, LEN_W'(idx_ff) < pos_ff, "key walk index beyond the key length")

endmodule
